// ===== design/assert_macros.svh =====
// assertion macros for the sequencer rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked only while the block is out of reset
`define ILS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define ILS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ILS_ASSERT(label, clk, rstn, prop, msg)
`define ILS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== design/ilseq_pkg.sv =====
// shared types, codes and helpers of the intersection light sequencer
// no dependencies
package ilseq_pkg;

    localparam int DEF_MAX_LIGHTS = 16;
    localparam int DEF_COORD_BITS = 8;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] GREEN_RESET  = 8'd10;
    localparam logic [7:0] YELLOW_RESET = 8'd4;

    localparam logic [1:0] CFG_LIGHT_COUNT = 2'd0;
    localparam logic [1:0] CFG_GREEN_TIME  = 2'd1;
    localparam logic [1:0] CFG_YELLOW_TIME = 2'd2;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_QUERY = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        COLOR_GREEN  = 2'd0,
        COLOR_YELLOW = 2'd1,
        COLOR_RED    = 2'd2,
        COLOR_NONE   = 2'd3
    } color_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_TICK,
        BS_QUERY
    } back_state_t;

    // one classified item as it travels through the queue
    typedef struct packed {
        mode_t      mode;
        logic [3:0] light_index;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       horizontal;
        logic [7:0] priority_x;
        logic [7:0] priority_y;
        logic       priority_x_valid;
        logic       priority_y_valid;
    } cmd_t;

    typedef struct packed {
        logic [4:0] lamps_used;
        logic [7:0] green_len;
        logic [7:0] yellow_len;
    } cfg_t;

    // one step toward the target, always through yellow
    function automatic color_t step_color(input color_t cur, input color_t tgt);
        color_t res;
        res = cur;
        if (cur != tgt) begin
            case (cur)
                COLOR_GREEN, COLOR_RED: res = COLOR_YELLOW;
                COLOR_YELLOW:           res = (tgt == COLOR_GREEN) ? COLOR_GREEN : COLOR_RED;
                default:                res = cur;
            endcase
        end
        return res;
    endfunction

endpackage

// ===== design/ilseq_front.sv =====
// front end: accepts input items, drops those that do nothing, builds commands
// depends on ilseq_pkg
module ilseq_front #(
    parameter int MAX_LIGHTS = ilseq_pkg::DEF_MAX_LIGHTS
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [3:0]        s_light_index,
    input  logic [7:0]        s_pos_x,
    input  logic [7:0]        s_pos_y,
    input  logic              s_horizontal,
    input  logic [7:0]        s_priority_x,
    input  logic [7:0]        s_priority_y,
    input  logic              s_priority_x_valid,
    input  logic              s_priority_y_valid,
    input  logic              queue_full,
    output logic              push,
    output ilseq_pkg::cmd_t   cmd
);
    import ilseq_pkg::*;

    logic keep;

    assign s_ready = !queue_full;

    always_comb begin
        case (s_mode)
            MODE_TICK:  keep = 1'b1;
            MODE_QUERY: keep = 1'b1;
            MODE_LOAD:  keep = (32'(s_light_index) < MAX_LIGHTS);
            default:    keep = 1'b0;
        endcase
    end

    assign push = s_valid && s_ready && keep;

    always_comb begin
        cmd.mode             = mode_t'(s_mode);
        cmd.light_index      = s_light_index;
        cmd.pos_x            = s_pos_x;
        cmd.pos_y            = s_pos_y;
        cmd.horizontal       = s_horizontal;
        cmd.priority_x       = s_priority_x;
        cmd.priority_y       = s_priority_y;
        cmd.priority_x_valid = s_priority_x_valid;
        cmd.priority_y_valid = s_priority_y_valid;
    end

endmodule

// ===== design/ilseq_queue.sv =====
// short command queue between front and back end
// depends on ilseq_pkg
module ilseq_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ilseq_pkg::cmd_t push_cmd,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop,
    output ilseq_pkg::cmd_t pop_cmd
);
    import ilseq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/ilseq_back.sv =====
// back end: light table, phase timer and the per-entry scan for ticks and queries
// depends on ilseq_pkg
module ilseq_back #(
    parameter int MAX_LIGHTS = ilseq_pkg::DEF_MAX_LIGHTS,
    parameter int COORD_BITS = ilseq_pkg::DEF_COORD_BITS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  ilseq_pkg::cfg_t cfg,
    input  logic            cmd_valid,
    input  ilseq_pkg::cmd_t cmd,
    output logic            cmd_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_kind,
    output logic [3:0]      m_report_index,
    output logic [1:0]      m_color,
    output logic            m_last
);
    import ilseq_pkg::*;

    localparam int IDX_W = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CNT_W = $clog2(MAX_LIGHTS + 1);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  horizontal;
        color_t                color;
    } entry_t;

    entry_t mem [MAX_LIGHTS];

    back_state_t           state_reg, state_next;
    logic [7:0]            counter_reg, counter_next;
    logic                  yellow_reg, yellow_next;
    logic                  axis_reg, axis_next;

    logic                  boundary_reg, boundary_next;
    logic                  axis_old_reg, axis_old_next;
    logic [COORD_BITS-1:0] key_x_reg, key_x_next;
    logic [COORD_BITS-1:0] key_y_reg, key_y_next;
    logic                  key_x_valid_reg, key_x_valid_next;
    logic                  key_y_valid_reg, key_y_valid_next;

    logic [CNT_W-1:0]      issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  data_valid_reg, data_valid_next;
    entry_t                rd_entry_reg;

    logic                  m_valid_reg;
    logic                  m_kind_reg;
    logic [3:0]            m_index_reg;
    color_t                m_color_reg;
    logic                  m_last_reg;

    logic [CNT_W-1:0]      n;
    logic                  slot_free;
    logic                  last_entry;
    logic                  hit;
    logic                  match;
    color_t                target;
    color_t                new_color;
    logic                  timer_end;

    logic                  consume;
    logic                  issue;
    logic                  emit;
    logic                  emit_kind;
    logic [3:0]            emit_index;
    color_t                emit_color;
    logic                  emit_last;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_data;

    always_comb begin
        if (32'(cfg.lamps_used) > MAX_LIGHTS) begin
            n = CNT_W'(MAX_LIGHTS);
        end else begin
            n = CNT_W'(cfg.lamps_used);
        end
    end

    assign slot_free  = !m_valid_reg || m_ready;
    assign last_entry = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == n);
    assign timer_end  = (counter_reg <= 8'd1);

    // key registers hold the priority coordinates on a tick, the position on a query
    assign hit = (key_x_valid_reg && rd_entry_reg.x == key_x_reg) ||
                 (key_y_valid_reg && rd_entry_reg.y == key_y_reg);
    assign match = (rd_entry_reg.x == key_x_reg) && (rd_entry_reg.y == key_y_reg);

    always_comb begin
        target = ((rd_entry_reg.horizontal == !axis_old_reg) || hit) ? COLOR_GREEN : COLOR_RED;
        new_color = boundary_reg ? step_color(rd_entry_reg.color, target) : rd_entry_reg.color;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.mode == MODE_TICK && n != '0) begin
                        state_next = BS_TICK;
                    end else if (cmd.mode == MODE_QUERY) begin
                        state_next = BS_QUERY;
                    end
                end
            end
            BS_TICK: begin
                if (data_valid_reg && slot_free && last_entry) begin
                    state_next = BS_IDLE;
                end
            end
            BS_QUERY: begin
                if (n == '0) begin
                    if (slot_free) begin
                        state_next = BS_IDLE;
                    end
                end else if (data_valid_reg && (match || last_entry) && slot_free) begin
                    state_next = BS_IDLE;
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    // control and datapath
    always_comb begin
        cmd_pop          = 1'b0;
        consume          = 1'b0;
        emit             = 1'b0;
        emit_kind        = KIND_TICK;
        emit_index       = 4'(rd_idx_reg);
        emit_color       = new_color;
        emit_last        = last_entry;
        mem_we           = 1'b0;
        wr_addr          = rd_idx_reg;
        wr_data          = rd_entry_reg;
        wr_data.color    = new_color;
        counter_next     = counter_reg;
        yellow_next      = yellow_reg;
        axis_next        = axis_reg;
        boundary_next    = boundary_reg;
        axis_old_next    = axis_old_reg;
        key_x_next       = key_x_reg;
        key_y_next       = key_y_reg;
        key_x_valid_next = key_x_valid_reg;
        key_y_valid_next = key_y_valid_reg;

        case (state_reg)
            BS_IDLE: begin
                cmd_pop = cmd_valid;
                if (cmd_valid) begin
                    case (cmd.mode)
                        MODE_LOAD: begin
                            mem_we             = 1'b1;
                            wr_addr            = IDX_W'(cmd.light_index);
                            wr_data.x          = COORD_BITS'(cmd.pos_x);
                            wr_data.y          = COORD_BITS'(cmd.pos_y);
                            wr_data.horizontal = cmd.horizontal;
                            wr_data.color      = cmd.horizontal ? COLOR_GREEN : COLOR_RED;
                        end
                        MODE_QUERY: begin
                            key_x_next = COORD_BITS'(cmd.pos_x);
                            key_y_next = COORD_BITS'(cmd.pos_y);
                        end
                        MODE_TICK: begin
                            key_x_next       = COORD_BITS'(cmd.priority_x);
                            key_y_next       = COORD_BITS'(cmd.priority_y);
                            key_x_valid_next = cmd.priority_x_valid;
                            key_y_valid_next = cmd.priority_y_valid;
                            boundary_next    = timer_end;
                            axis_old_next    = axis_reg;
                            if (!timer_end) begin
                                counter_next = counter_reg - 8'd1;
                            end else if (!yellow_reg) begin
                                yellow_next  = 1'b1;
                                counter_next = cfg.yellow_len;
                            end else begin
                                axis_next    = !axis_reg;
                                yellow_next  = 1'b0;
                                counter_next = cfg.green_len;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BS_TICK: begin
                consume = data_valid_reg && slot_free;
                emit    = consume;
                mem_we  = consume;
            end
            BS_QUERY: begin
                emit_kind = KIND_QUERY;
                emit_last = 1'b1;
                if (n == '0) begin
                    emit       = slot_free;
                    emit_index = 4'd0;
                    emit_color = COLOR_NONE;
                end else begin
                    consume    = data_valid_reg && (!(match || last_entry) || slot_free);
                    emit       = consume && (match || last_entry);
                    emit_index = match ? 4'(rd_idx_reg) : 4'd0;
                    emit_color = match ? rd_entry_reg.color : COLOR_NONE;
                end
            end
            default: ;
        endcase
    end

    // read-ahead over the table; a stalled entry is read again at the same address
    always_comb begin
        issue = (state_reg == BS_TICK || state_reg == BS_QUERY) &&
                (issue_idx_reg < n) && (!data_valid_reg || consume);
        rd_addr = (data_valid_reg && !consume) ? rd_idx_reg : issue_idx_reg[IDX_W-1:0];
        if (state_reg == BS_IDLE) begin
            issue_idx_next  = '0;
            rd_idx_next     = rd_idx_reg;
            data_valid_next = 1'b0;
        end else begin
            issue_idx_next  = issue ? issue_idx_reg + CNT_W'(1) : issue_idx_reg;
            rd_idx_next     = issue ? issue_idx_reg[IDX_W-1:0] : rd_idx_reg;
            data_valid_next = issue || (data_valid_reg && !consume);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BS_IDLE;
            counter_reg    <= GREEN_RESET;
            yellow_reg     <= 1'b0;
            axis_reg       <= 1'b0;
            issue_idx_reg  <= '0;
            data_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            counter_reg    <= counter_next;
            yellow_reg     <= yellow_next;
            axis_reg       <= axis_next;
            issue_idx_reg  <= issue_idx_next;
            data_valid_reg <= data_valid_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        boundary_reg    <= boundary_next;
        axis_old_reg    <= axis_old_next;
        key_x_reg       <= key_x_next;
        key_y_reg       <= key_y_next;
        key_x_valid_reg <= key_x_valid_next;
        key_y_valid_reg <= key_y_valid_next;
        rd_idx_reg      <= rd_idx_next;
        if (emit) begin
            m_kind_reg  <= emit_kind;
            m_index_reg <= emit_index;
            m_color_reg <= emit_color;
            m_last_reg  <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        rd_entry_reg <= mem[rd_addr];
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_report_index = m_index_reg;
    assign m_color        = m_color_reg;
    assign m_last         = m_last_reg;

endmodule

// ===== design/intersection_light_sequencer_core.sv =====
// intersection light sequencer: ticks and queries scan the light table one entry per cycle
// through its single read port while the output is not stalled, a query stopping at its
// first match; a 4-deep command queue takes items while the back end works. aresetn
// (synchronous, active low) sets the timer to green with 10 ticks, horizontal axis open,
// count 0, green 10, yellow 4; the table is not cleared
`include "assert_macros.svh"

module intersection_light_sequencer_core #(
    parameter int MAX_LIGHTS = ilseq_pkg::DEF_MAX_LIGHTS,
    parameter int COORD_BITS = ilseq_pkg::DEF_COORD_BITS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [3:0] s_light_index,
    input  logic [7:0] s_pos_x,
    input  logic [7:0] s_pos_y,
    input  logic       s_horizontal,
    input  logic [7:0] s_priority_x,
    input  logic [7:0] s_priority_y,
    input  logic       s_priority_x_valid,
    input  logic       s_priority_y_valid,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [3:0] m_report_index,
    output logic [1:0] m_color,
    output logic       m_last
);
    import ilseq_pkg::*;

    logic [4:0] lamps_used_reg;
    logic [7:0] green_len_reg;
    logic [7:0] yellow_len_reg;
    cfg_t       cfg;

    logic       queue_full;
    logic       push;
    cmd_t       push_cmd;
    logic       pop_valid;
    logic       pop;
    cmd_t       pop_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lamps_used_reg <= 5'd0;
            green_len_reg  <= GREEN_RESET;
            yellow_len_reg <= YELLOW_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LIGHT_COUNT: lamps_used_reg <= cfg_wdata[4:0];
                CFG_GREEN_TIME:  green_len_reg  <= cfg_wdata;
                CFG_YELLOW_TIME: yellow_len_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.lamps_used = lamps_used_reg;
        cfg.green_len  = green_len_reg;
        cfg.yellow_len = yellow_len_reg;
    end

    ilseq_front #(
        .MAX_LIGHTS(MAX_LIGHTS)
    ) u_front (
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_light_index      (s_light_index),
        .s_pos_x            (s_pos_x),
        .s_pos_y            (s_pos_y),
        .s_horizontal       (s_horizontal),
        .s_priority_x       (s_priority_x),
        .s_priority_y       (s_priority_y),
        .s_priority_x_valid (s_priority_x_valid),
        .s_priority_y_valid (s_priority_y_valid),
        .queue_full         (queue_full),
        .push               (push),
        .cmd                (push_cmd)
    );

    ilseq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_cmd   (pop_cmd)
    );

    ilseq_back #(
        .MAX_LIGHTS(MAX_LIGHTS),
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd_valid      (pop_valid),
        .cmd            (pop_cmd),
        .cmd_pop        (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_report_index (m_report_index),
        .m_color        (m_color),
        .m_last         (m_last)
    );

    // no result may be pending right after reset
    `ILS_ASSERT_ALWAYS(a_reset_clears_output, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // a query result is always marked last
    `ILS_ASSERT(a_query_is_last, aclk, aresetn, m_valid && m_kind == KIND_QUERY |-> m_last, "query answer without last")

    // tick reports only describe entries in use
    `ILS_ASSERT(a_tick_index_in_use, aclk, aresetn, m_valid && m_kind == KIND_TICK |-> 5'(m_report_index) < lamps_used_reg, "tick report beyond light count")

    // a none color only answers a query
    `ILS_ASSERT(a_none_only_query, aclk, aresetn, m_valid && m_color == COLOR_NONE |-> m_kind == KIND_QUERY, "none color on a tick report")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// testbench for intersection_light_sequencer_core: a directed table, then random phases,
// all results checked in order against an in-bench light table; needs ilseq_pkg and the core
module tb;
    import ilseq_pkg::*;

    localparam int         TABLE_SIZE      = DEF_MAX_LIGHTS;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES   = 100;
    localparam int         CYCLE_LIMIT     = 600000;
    localparam int         ITEMS_PER_PHASE = 42;
    localparam int         NUM_PHASES      = 8;

    // what a directed row expects: the in-bench table, nothing, or a typed query miss
    localparam int WANT_MODEL = -1;
    localparam int WANT_NONE  = 0;
    localparam int WANT_MISS  = 1;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] light_index;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       horizontal;
        logic [7:0] priority_x;
        logic [7:0] priority_y;
        logic       priority_x_valid;
        logic       priority_y_valid;
    } light_item_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] report_index;
        color_t     color;
        logic       last;
    } light_report_t;

    typedef struct packed {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [7:0]  reg_val;
        light_item_t item;
        int          want;
    } stim_row_t;

    logic       aclk               = 1'b0;
    logic       aresetn            = 1'b0;
    logic       cfg_we             = 1'b0;
    logic [1:0] cfg_index          = CFG_LIGHT_COUNT;
    logic [7:0] cfg_wdata          = '0;
    logic       s_valid            = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode             = '0;
    logic [3:0] s_light_index      = '0;
    logic [7:0] s_pos_x            = '0;
    logic [7:0] s_pos_y            = '0;
    logic       s_horizontal       = 1'b0;
    logic [7:0] s_priority_x       = '0;
    logic [7:0] s_priority_y       = '0;
    logic       s_priority_x_valid = 1'b0;
    logic       s_priority_y_valid = 1'b0;
    logic       m_valid;
    logic       m_ready            = 1'b0;
    logic       m_kind;
    logic [3:0] m_report_index;
    logic [1:0] m_color;
    logic       m_last;

    // in-bench copy of the light table, phase timer and registers
    logic [7:0] lt_x     [TABLE_SIZE];
    logic [7:0] lt_y     [TABLE_SIZE];
    logic       lt_horiz [TABLE_SIZE];
    color_t     lt_color [TABLE_SIZE];
    logic       yellow_phase;
    logic [7:0] phase_left;
    logic       vertical_open;
    logic [4:0] reg_count;
    logic [7:0] reg_green;
    logic [7:0] reg_yellow;

    light_report_t due_reports[$];
    light_report_t fresh_reports[$];
    light_report_t head_report;

    int fail_count   = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    int items_sent   = 0;
    int ticks_sent   = 0;
    int loads_sent   = 0;
    int queries_sent = 0;
    int reg_writes   = 0;
    int reports_seen = 0;
    bit rx_choppy;

    logic [7:0] phase_count      [NUM_PHASES] = '{8'd4, 8'd16, 8'd31, 8'd1, 8'd17, 8'd0, 8'd9, 8'd16};
    logic [7:0] green_per_phase  [NUM_PHASES] = '{8'd0, 8'd10, 8'd0, 8'd255, 8'd3, 8'd1, 8'd5, 8'd2};
    logic [7:0] yellow_per_phase [NUM_PHASES] = '{8'd0, 8'd4, 8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd1};

    intersection_light_sequencer_core DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_light_index      (s_light_index),
        .s_pos_x            (s_pos_x),
        .s_pos_y            (s_pos_y),
        .s_horizontal       (s_horizontal),
        .s_priority_x       (s_priority_x),
        .s_priority_y       (s_priority_y),
        .s_priority_x_valid (s_priority_x_valid),
        .s_priority_y_valid (s_priority_y_valid),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_report_index     (m_report_index),
        .m_color            (m_color),
        .m_last             (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // goal is always green or red; a light never jumps between them directly
    function automatic color_t next_color(input color_t now, input color_t goal);
        if (now == goal)
            return now;
        if (now == COLOR_YELLOW)
            return goal;
        return COLOR_YELLOW;
    endfunction

    task automatic step_lights(input light_item_t it);
        int     n;
        bit     found;
        bit     boundary;
        bit     open_axis;
        bit     on_priority;
        color_t goal [TABLE_SIZE];
        n = (reg_count > TABLE_SIZE) ? TABLE_SIZE : int'(reg_count);
        case (it.mode)
            MODE_LOAD: begin
                lt_x[it.light_index]     = it.pos_x;
                lt_y[it.light_index]     = it.pos_y;
                lt_horiz[it.light_index] = it.horizontal;
                lt_color[it.light_index] = it.horizontal ? COLOR_GREEN : COLOR_RED;
            end
            MODE_QUERY: begin
                found = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (!found && lt_x[i] == it.pos_x && lt_y[i] == it.pos_y) begin
                        found = 1'b1;
                        fresh_reports.push_back('{KIND_QUERY, 4'(i), lt_color[i], 1'b1});
                    end
                end
                if (!found)
                    fresh_reports.push_back('{KIND_QUERY, 4'd0, COLOR_NONE, 1'b1});
            end
            MODE_TICK: begin
                // goals use the axis open before this tick's flip
                for (int i = 0; i < n; i++) begin
                    open_axis   = (lt_horiz[i] == !vertical_open);
                    on_priority = (it.priority_x_valid && lt_x[i] == it.priority_x) ||
                                  (it.priority_y_valid && lt_y[i] == it.priority_y);
                    goal[i] = (open_axis || on_priority) ? COLOR_GREEN : COLOR_RED;
                end
                boundary = (phase_left <= 8'd1);
                if (!boundary) begin
                    phase_left = phase_left - 8'd1;
                end else if (!yellow_phase) begin
                    yellow_phase = 1'b1;
                    phase_left   = reg_yellow;
                end else begin
                    vertical_open = !vertical_open;
                    yellow_phase  = 1'b0;
                    phase_left    = reg_green;
                end
                for (int i = 0; i < n; i++) begin
                    if (boundary)
                        lt_color[i] = next_color(lt_color[i], goal[i]);
                    fresh_reports.push_back('{KIND_TICK, 4'(i), lt_color[i], i == n - 1});
                end
            end
            default: ;
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input light_item_t it, input int want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_mode             = it.mode;
        s_light_index      = it.light_index;
        s_pos_x            = it.pos_x;
        s_pos_y            = it.pos_y;
        s_horizontal       = it.horizontal;
        s_priority_x       = it.priority_x;
        s_priority_y       = it.priority_y;
        s_priority_x_valid = it.priority_x_valid;
        s_priority_y_valid = it.priority_y_valid;
        s_valid            = 1'b1;
        do @(posedge aclk); while (!s_ready);
        step_lights(it);
        if (want == WANT_MODEL) begin
            foreach (fresh_reports[k])
                due_reports.push_back(fresh_reports[k]);
        end else if (want == WANT_MISS) begin
            due_reports.push_back('{KIND_QUERY, 4'd0, COLOR_NONE, 1'b1});
        end
        fresh_reports.delete();
        items_sent++;
        case (it.mode)
            MODE_TICK:  ticks_sent++;
            MODE_LOAD:  loads_sent++;
            MODE_QUERY: queries_sent++;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // loads and empty ticks give no result, so the back end may still be busy
    task automatic settle();
        s_valid = 1'b0;
        while (due_reports.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            CFG_LIGHT_COUNT: reg_count  = val[4:0];
            CFG_GREEN_TIME:  reg_green  = val;
            CFG_YELLOW_TIME: reg_yellow = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    function automatic light_item_t random_item();
        light_item_t it;
        int          pick;
        int          src;
        it.light_index      = 4'($urandom_range(0, 15));
        it.pos_x            = 8'($urandom_range(0, 255));
        it.pos_y            = 8'($urandom_range(0, 255));
        it.horizontal       = 1'($urandom_range(0, 1));
        it.priority_x       = 8'($urandom_range(0, 255));
        it.priority_y       = 8'($urandom_range(0, 255));
        it.priority_x_valid = 1'($urandom_range(0, 1));
        it.priority_y_valid = 1'($urandom_range(0, 1));
        src  = $urandom_range(0, TABLE_SIZE - 1);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            it.mode = MODE_TICK;
            // aim priority at real lights most of the time
            if ($urandom_range(0, 2) != 0)
                it.priority_x = lt_x[src];
            if ($urandom_range(0, 2) != 0)
                it.priority_y = lt_y[$urandom_range(0, TABLE_SIZE - 1)];
        end else if (pick < 65) begin
            it.mode = MODE_LOAD;
            if ($urandom_range(0, 4) == 0) begin
                it.pos_x = lt_x[src];
                it.pos_y = lt_y[src];
            end else if ($urandom_range(0, 4) == 0) begin
                it.pos_x = $urandom_range(0, 1) ? 8'hff : 8'h00;
                it.pos_y = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
        end else if (pick < 95) begin
            it.mode = MODE_QUERY;
            if ($urandom_range(0, 9) < 7) begin
                it.pos_x = lt_x[src];
                it.pos_y = lt_y[src];
            end
        end else begin
            it.mode = MODE_UNUSED;
        end
        return it;
    endfunction

    function automatic stim_row_t item_row(input logic [1:0] mode, input logic [3:0] idx,
                                           input logic [7:0] x, input logic [7:0] y,
                                           input logic h, input logic [7:0] px,
                                           input logic [7:0] py, input logic pxv,
                                           input logic pyv, input int want);
        stim_row_t row;
        row.is_cfg  = 1'b0;
        row.reg_idx = CFG_LIGHT_COUNT;
        row.reg_val = '0;
        row.item    = '{mode, idx, x, y, h, px, py, pxv, pyv};
        row.want    = want;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [7:0] val);
        stim_row_t row;
        row         = item_row(MODE_UNUSED, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0,
                               WANT_NONE);
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic void check_field(input string name, input logic [3:0] expv,
                                        input logic [3:0] act);
        if (act !== expv) begin
            $error("%s: expected %0d, got %0d", name, expv, act);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            if (due_reports.size() == 0) begin
                $error("unexpected result: kind %0d index %0d color %0d last %0d",
                       m_kind, m_report_index, m_color, m_last);
                fail_count++;
            end else begin
                head_report = due_reports.pop_front();
                check_field("kind", 4'(head_report.kind), 4'(m_kind));
                check_field("report_index", head_report.report_index, m_report_index);
                check_field("color", 4'(head_report.color), 4'(m_color));
                check_field("last", 4'(head_report.last), 4'(m_last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     due_reports.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: open stretches, choppy stretches, and an occasional hard stall
    initial begin
        forever begin
            rx_choppy = 1'($urandom_range(0, 1));
            repeat ($urandom_range(10, 60)) begin
                @(negedge aclk);
                m_ready = rx_choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
            end
            repeat ($urandom_range(0, 8)) begin
                @(negedge aclk);
                m_ready = 1'b0;
            end
        end
    end

    initial begin
        stim_row_t   rows[$];
        light_item_t it;
        yellow_phase  = 1'b0;
        phase_left    = GREEN_RESET;
        vertical_open = 1'b0;
        reg_count     = '0;
        reg_green     = GREEN_RESET;
        reg_yellow    = YELLOW_RESET;
        foreach (lt_x[i]) begin
            lt_x[i]     = '0;
            lt_y[i]     = '0;
            lt_horiz[i] = 1'b0;
            lt_color[i] = COLOR_GREEN;
        end

        // no lights in use: the timer runs, a query misses, the unused mode is dropped
        rows.push_back(item_row(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0,
                                WANT_NONE));
        rows.push_back(item_row(MODE_QUERY, 4'hf, 8'd0, 8'd0, 1'b1, 8'hff, 8'hff, 1'b1, 1'b1,
                                WANT_MISS));
        rows.push_back(item_row(MODE_UNUSED, 4'hf, 8'hff, 8'hff, 1'b1, 8'hff, 8'hff, 1'b1,
                                1'b1, WANT_NONE));
        // entry 3 shares entry 0's position, entry 15 lies past the count
        rows.push_back(item_row(MODE_LOAD, 4'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0, 1'b0, 1'b0,
                                WANT_NONE));
        rows.push_back(item_row(MODE_LOAD, 4'd1, 8'hff, 8'hff, 1'b0, 8'hff, 8'hff, 1'b1, 1'b1,
                                WANT_NONE));
        rows.push_back(item_row(MODE_LOAD, 4'd2, 8'd10, 8'd20, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0,
                                WANT_NONE));
        rows.push_back(item_row(MODE_LOAD, 4'd3, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0,
                                WANT_NONE));
        rows.push_back(item_row(MODE_LOAD, 4'hf, 8'h80, 8'h7f, 1'b1, 8'd0, 8'd0, 1'b0, 1'b0,
                                WANT_NONE));
        rows.push_back(cfg_row(CFG_LIGHT_COUNT, 8'd4));
        rows.push_back(cfg_row(CFG_GREEN_TIME, 8'd0));
        rows.push_back(cfg_row(CFG_YELLOW_TIME, 8'd0));
        rows.push_back(item_row(MODE_QUERY, 4'd0, 8'hff, 8'hff, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0,
                                WANT_MODEL));
        rows.push_back(item_row(MODE_QUERY, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0,
                                WANT_MODEL));
        rows.push_back(item_row(MODE_QUERY, 4'd0, 8'h80, 8'h7f, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0,
                                WANT_MISS));
        // zero phase times only load at the next boundary; these ticks count down from reset
        rows.push_back(item_row(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0,
                                WANT_MODEL));
        rows.push_back(item_row(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b0, 8'd10, 8'd0, 1'b1, 1'b0,
                                WANT_MODEL));
        rows.push_back(item_row(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1,
                                WANT_MODEL));
        rows.push_back(item_row(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b0, 8'hff, 8'hff, 1'b1, 1'b1,
                                WANT_MODEL));
        rows.push_back(item_row(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0,
                                WANT_MODEL));
        rows.push_back(item_row(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd20, 1'b0, 1'b1,
                                WANT_MODEL));
        rows.push_back(item_row(MODE_QUERY, 4'd0, 8'd10, 8'd20, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0,
                                WANT_MODEL));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[r]) begin
            if (rows[r].is_cfg) begin
                settle();
                write_reg(rows[r].reg_idx, rows[r].reg_val);
            end else begin
                send_item(rows[r].item, rows[r].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_reg(CFG_LIGHT_COUNT, phase_count[p]);
            write_reg(CFG_GREEN_TIME, green_per_phase[p]);
            write_reg(CFG_YELLOW_TIME, yellow_per_phase[p]);
            // fill the whole table before any count can reach an unloaded entry
            if (p == 0) begin
                for (int k = 0; k < TABLE_SIZE; k++) begin
                    it             = random_item();
                    it.mode        = MODE_LOAD;
                    it.light_index = 4'(k);
                    send_item(it, WANT_MODEL);
                end
            end
            repeat (ITEMS_PER_PHASE) send_item(random_item(), WANT_MODEL);
        end

        settle();
        $display("sent %0d items: %0d ticks, %0d loads, %0d queries, %0d register writes",
                 items_sent, ticks_sent, loads_sent, queries_sent, reg_writes);
        $display("compared %0d results over light counts 0..31 and phase times 0..255",
                 reports_seen);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
